>>> hdl/pidc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants, register indexes, step codes and control structs for the
// positional PID step block.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // pi and 2*pi in Q16.16
    localparam logic signed [33:0] PI_Q16     = 34'sd205887;
    localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

    // build-time options
    localparam logic [30:0] I_TERM_LIMIT = 31'd0;
    localparam logic [30:0] I_SEPARATE   = 31'd0;
    localparam logic        D_ON_MEASURE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_KP        = 3'd0;
    localparam logic [2:0] REG_KI_DT     = 3'd1;
    localparam logic [2:0] REG_KD_OVER_DT = 3'd2;
    localparam logic [2:0] REG_KF        = 3'd3;
    localparam logic [2:0] REG_OUT_LIMIT = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND = 3'd5;
    localparam logic [2:0] REG_SLOW_LO   = 3'd6;
    localparam logic [2:0] REG_SLOW_HI   = 3'd7;

    // datapath step codes
    localparam logic [3:0] STEP_NONE  = 4'd0;
    localparam logic [3:0] STEP_ERR   = 4'd1;
    localparam logic [3:0] STEP_RATIO = 4'd2;
    localparam logic [3:0] STEP_P     = 4'd3;
    localparam logic [3:0] STEP_S     = 4'd4;
    localparam logic [3:0] STEP_I     = 4'd5;
    localparam logic [3:0] STEP_D     = 4'd6;
    localparam logic [3:0] STEP_F     = 4'd7;
    localparam logic [3:0] STEP_SUM   = 4'd8;

    localparam logic signed [50:0] S32_MAX = 51'sd2147483647;
    localparam logic signed [50:0] S32_MIN = -51'sd2147483648;

    typedef struct packed {
        logic       load;
        logic [3:0] step;
        logic       div_start;
    } pidc_cmd_t;

    typedef struct packed {
        logic div_needed;
        logic div_done;
        logic out_busy;
    } pidc_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pidc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_div
// Restoring divider for the integration speed ratio: (num << 16) / den with
// num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [30:0] num,
    input  wire logic [30:0] den,
    output logic             done,
    output logic [15:0]      quo
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] den_reg, den_next;
    logic [15:0] quo_reg, quo_next;
    logic [31:0] rem2;
    logic [31:0] diff;
    logic        ge;

    always_comb begin
        rem2 = {rem_reg, 1'b0};
        ge = rem2 >= {1'b0, den_reg};
        diff = rem2 - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 4'd15;
            rem_next = num;
            den_next = den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[30:0] : rem2[30:0];
            quo_next = {quo_reg[14:0], ge};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule
`default_nettype wire

>>> hdl/pidc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_datapath
// Configuration registers, controller state, shared multiplier, speed-ratio
// divider and output register of the PID step.
// ----------------------------------------------------------------------------
module pidc_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_req_type,
    input  wire logic signed [31:0] s_setpoint,
    input  wire logic signed [31:0] s_measured,
    input  wire pidc_pkg::pidc_cmd_t cmd,
    output pidc_pkg::pidc_stat_t    stat,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic signed [31:0]      m_drive,
    output logic                    m_clamped
);
    import pidc_pkg::*;

    // configuration
    logic signed [31:0] kp_reg, kd_reg, kf_reg;
    logic [30:0] ki_reg, out_limit_reg, dead_band_reg, slow_lo_reg, slow_hi_reg;

    // sample and work registers
    logic               req_type_reg;
    logic signed [31:0] sp_reg, meas_reg;
    logic signed [31:0] err_reg, err_next;
    logic [31:0]        aerr_reg, aerr_next;
    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [31:0] dm_reg, dm_next;
    logic signed [31:0] dt_reg, dt_next;
    logic [16:0]        ratio_reg, ratio_next;
    logic               zclr_reg, zclr_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [47:0] p_reg, p_next;
    logic signed [47:0] iout_reg;
    logic signed [31:0] d_reg, d_next;

    // controller state
    logic signed [47:0] integ_reg, integ_next;
    logic signed [31:0] last_meas_reg, last_meas_next;
    logic signed [31:0] last_tgt_reg, last_tgt_next;
    logic signed [31:0] last_err_reg, last_err_next;
    logic signed [31:0] last_drive_reg, last_drive_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] drive_reg, drive_next;
    logic               clamped_reg, clamped_next;

    logic signed [33:0] diff_raw, diff_wrap;
    logic signed [31:0] err_sat, err_dz;
    logic [32:0]        err_neg;
    logic [31:0]        aerr_raw;
    logic               in_zone;
    logic               speed_en, le_lo, ge_hi;
    logic [30:0]        div_num, div_den;
    logic               div_done;
    logic [15:0]        div_quo;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] product;
    logic signed [47:0] prod_hi;
    logic signed [47:0] acc0, acc1, acc2, acc3;
    logic signed [48:0] acc_sum;
    logic signed [47:0] itl;
    logic [32:0]        ld_neg;
    logic [31:0]        ld_abs;
    logic               windup, sep_ok;
    logic signed [48:0] d_raw;
    logic signed [50:0] sum, lim, clip;
    logic signed [31:0] drive_w;

    // ---------------- configuration writes ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            kf_reg <= '0;
            out_limit_reg <= '0;
            dead_band_reg <= '0;
            slow_lo_reg <= '0;
            slow_hi_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KP:         kp_reg <= cfg_data;
                REG_KI_DT:      ki_reg <= cfg_data[30:0];
                REG_KD_OVER_DT: kd_reg <= cfg_data;
                REG_KF:         kf_reg <= cfg_data;
                REG_OUT_LIMIT:  out_limit_reg <= cfg_data[30:0];
                REG_DEAD_BAND:  dead_band_reg <= cfg_data[30:0];
                REG_SLOW_LO:    slow_lo_reg <= cfg_data[30:0];
                REG_SLOW_HI:    slow_hi_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- error, wrap and dead zone ----------------
    always_comb begin
        diff_raw = {{2{sp_reg[31]}}, sp_reg} - {{2{meas_reg[31]}}, meas_reg};
        diff_wrap = diff_raw;
        if (req_type_reg) begin
            if (diff_raw > PI_Q16) begin
                diff_wrap = diff_raw - TWO_PI_Q16;
            end else if (diff_raw < -PI_Q16) begin
                diff_wrap = diff_raw + TWO_PI_Q16;
            end
        end
        err_sat = sat32(51'(diff_wrap));
        err_neg = -{err_sat[31], err_sat};
        aerr_raw = err_sat[31] ? err_neg[31:0] : err_sat;
        in_zone = aerr_raw < {1'b0, dead_band_reg};
        if (in_zone) begin
            err_dz = '0;
        end else if (err_sat > 0) begin
            err_dz = err_sat - $signed({1'b0, dead_band_reg});
        end else if (err_sat < 0) begin
            err_dz = err_sat + $signed({1'b0, dead_band_reg});
        end else begin
            err_dz = err_sat;
        end
    end

    // ---------------- speed ratio ----------------
    always_comb begin
        speed_en = (slow_lo_reg != '0) || (slow_hi_reg != '0);
        le_lo = aerr_reg <= {1'b0, slow_lo_reg};
        ge_hi = aerr_reg >= {1'b0, slow_hi_reg};
        div_num = slow_hi_reg - aerr_reg[30:0];
        div_den = slow_hi_reg - slow_lo_reg;
    end

    pidc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------- shared multiplier operands ----------------
    always_comb begin
        prod_hi = prod_reg[63:16];
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_P: begin
                mul_a = 33'(kp_reg);
                mul_b = 33'(err_reg);
            end
            STEP_S: begin
                mul_a = $signed({16'd0, ratio_reg});
                mul_b = 33'(err_reg);
            end
            STEP_I: begin
                mul_a = $signed({2'b00, ki_reg});
                mul_b = 33'($signed(prod_reg[47:16]));
            end
            STEP_D: begin
                mul_a = 33'(kd_reg);
                mul_b = 33'(dm_reg);
            end
            STEP_F: begin
                mul_a = 33'(kf_reg);
                mul_b = 33'(dt_reg);
            end
            default: ;
        endcase
        product = mul_a * mul_b;
    end

    // ---------------- integral update ----------------
    always_comb begin
        itl = $signed({17'd0, I_TERM_LIMIT});
        acc0 = zclr_reg ? '0 : integ_reg;
        acc1 = acc0;
        if ((I_TERM_LIMIT != '0) && (ki_reg != '0)) begin
            if (acc0 > itl) begin
                acc1 = itl;
            end else if (acc0 < -itl) begin
                acc1 = -itl;
            end
        end
        ld_neg = -{last_drive_reg[31], last_drive_reg};
        ld_abs = last_drive_reg[31] ? ld_neg[31:0] : last_drive_reg;
        windup = ((out_limit_reg != '0) && (ld_abs >= {1'b0, out_limit_reg}))
               || ((last_err_reg > 0) && (err_reg < 0))
               || ((last_err_reg < 0) && (err_reg > 0));
        acc2 = windup ? '0 : acc1;
        sep_ok = (I_SEPARATE == '0) || (aerr_reg < {1'b0, I_SEPARATE});
        acc_sum = {acc2[47], acc2} + {prod_hi[47], prod_hi};
        // saturate to the 48-bit range
        if (acc_sum[48] != acc_sum[47]) begin
            acc3 = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            acc3 = acc_sum[47:0];
        end
    end

    // ---------------- sum and clamp ----------------
    always_comb begin
        d_raw = D_ON_MEASURE ? -{prod_hi[47], prod_hi} : {prod_hi[47], prod_hi};
        sum = 51'(p_reg) + 51'(iout_reg) + 51'(d_reg) + 51'(prod_hi);
        lim = $signed({20'd0, out_limit_reg});
        clip = sum;
        if (out_limit_reg != '0) begin
            if (sum > lim) begin
                clip = lim;
            end else if (sum < -lim) begin
                clip = -lim;
            end
        end
        drive_w = sat32(clip);
    end

    // ---------------- step sequencing ----------------
    always_comb begin
        err_next = err_reg;
        aerr_next = aerr_reg;
        tgt_next = tgt_reg;
        dm_next = dm_reg;
        dt_next = dt_reg;
        ratio_next = ratio_reg;
        zclr_next = zclr_reg;
        prod_next = prod_reg;
        p_next = p_reg;
        d_next = d_reg;
        integ_next = integ_reg;
        last_meas_next = last_meas_reg;
        last_tgt_next = last_tgt_reg;
        last_err_next = last_err_reg;
        last_drive_next = last_drive_reg;
        drive_next = drive_reg;
        clamped_next = clamped_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (div_done) begin
            ratio_next = {1'b0, div_quo};
        end

        case (cmd.step)
            STEP_ERR: begin
                err_next = err_dz;
                aerr_next = in_zone ? '0 : aerr_raw - {1'b0, dead_band_reg};
                tgt_next = in_zone ? meas_reg : sp_reg;
                dm_next = sat32(51'(meas_reg) - 51'(last_meas_reg));
            end
            STEP_RATIO: begin
                dt_next = sat32(51'(tgt_reg) - 51'(last_tgt_reg));
                if (!D_ON_MEASURE) begin
                    dm_next = sat32(51'(err_reg) - 51'(last_err_reg));
                end
                zclr_next = speed_en && !le_lo && ge_hi;
                if (!speed_en || le_lo) begin
                    ratio_next = 17'h10000;
                end else if (ge_hi) begin
                    ratio_next = '0;
                end
            end
            STEP_P: begin
                prod_next = product[63:0];
            end
            STEP_S: begin
                p_next = prod_hi;
                prod_next = product[63:0];
            end
            STEP_I: begin
                prod_next = product[63:0];
            end
            STEP_D: begin
                integ_next = sep_ok ? acc3 : '0;
                prod_next = product[63:0];
            end
            STEP_F: begin
                d_next = sat32(51'(d_raw));
                prod_next = product[63:0];
            end
            STEP_SUM: begin
                drive_next = drive_w;
                clamped_next = 51'(drive_w) != sum;
                m_valid_next = 1'b1;
                last_meas_next = meas_reg;
                last_tgt_next = tgt_reg;
                last_err_next = err_reg;
                last_drive_next = drive_w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            last_meas_reg <= '0;
            last_tgt_reg <= '0;
            last_err_reg <= '0;
            last_drive_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            integ_reg <= integ_next;
            last_meas_reg <= last_meas_next;
            last_tgt_reg <= last_tgt_next;
            last_err_reg <= last_err_next;
            last_drive_reg <= last_drive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            sp_reg <= s_setpoint;
            meas_reg <= s_measured;
        end
        if (cmd.step == STEP_D) begin
            iout_reg <= sep_ok ? acc3 : '0;
        end
        err_reg <= err_next;
        aerr_reg <= aerr_next;
        tgt_reg <= tgt_next;
        dm_reg <= dm_next;
        dt_reg <= dt_next;
        ratio_reg <= ratio_next;
        zclr_reg <= zclr_next;
        prod_reg <= prod_next;
        p_reg <= p_next;
        d_reg <= d_next;
        drive_reg <= drive_next;
        clamped_reg <= clamped_next;
    end

    assign stat.div_needed = speed_en && !le_lo && !ge_hi;
    assign stat.div_done = div_done;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;
    assign m_clamped = clamped_reg;

endmodule
`default_nettype wire

>>> hdl/pidc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_ctrl
// Step sequencer of the PID update: accept a sample, walk the datapath
// through error, ratio, the five products and the final sum.
// ----------------------------------------------------------------------------
module pidc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pidc_pkg::pidc_stat_t stat,
    output pidc_pkg::pidc_cmd_t       cmd
);
    import pidc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_RATIO = 4'd2;
    localparam logic [3:0] ST_DIVW  = 4'd3;
    localparam logic [3:0] ST_P     = 4'd4;
    localparam logic [3:0] ST_S     = 4'd5;
    localparam logic [3:0] ST_I     = 4'd6;
    localparam logic [3:0] ST_D     = 4'd7;
    localparam logic [3:0] ST_F     = 4'd8;
    localparam logic [3:0] ST_SUM   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.load = 1'b0;
        cmd.step = STEP_NONE;
        cmd.div_start = 1'b0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.step = STEP_ERR;
                state_next = ST_RATIO;
            end
            ST_RATIO: begin
                cmd.step = STEP_RATIO;
                if (stat.div_needed) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIVW;
                end else begin
                    state_next = ST_P;
                end
            end
            ST_DIVW: begin
                if (stat.div_done) begin
                    state_next = ST_P;
                end
            end
            ST_P: begin
                cmd.step = STEP_P;
                state_next = ST_S;
            end
            ST_S: begin
                cmd.step = STEP_S;
                state_next = ST_I;
            end
            ST_I: begin
                cmd.step = STEP_I;
                state_next = ST_D;
            end
            ST_D: begin
                cmd.step = STEP_D;
                state_next = ST_F;
            end
            ST_F: begin
                cmd.step = STEP_F;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // hold until the output register is free
                if (!stat.out_busy) begin
                    cmd.step = STEP_SUM;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_ERR)
        else $error("accepted transaction did not start the error step");

    a_div_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVW && stat.div_done |=> state_reg == ST_P)
        else $error("divider finish did not resume the product steps");

    a_sum_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUM && stat.out_busy |=> state_reg == ST_SUM)
        else $error("result committed while output register occupied");

endmodule
`default_nettype wire

>>> hdl/pid_controller_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_step
// Positional Q16.16 PID step with dead zone, variable-speed integration,
// anti-windup, derivative on measurement, feedforward and output clamp.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction
//  s_        s_valid s_ready s_req_type s_setpoint   in
//            s_measured
//  m_        m_valid m_ready m_drive m_clamped       out
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data  in
//
//  A sample steps through error, ratio, the five products and the sum before
//  the next acceptance; the sum step registers the result. When the error lies
//  strictly inside the slow band the 16-step ratio divider runs after ratio.
//  One multiplier is shared by the five products, one per cycle.
//  Synchronous active-low reset clears controller state and configuration.
//  A held result stalls the final step; the sample is taken only when idle.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_controller_step (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic signed [31:0] s_setpoint,
    input  wire logic signed [31:0] s_measured,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_drive,
    output logic                    m_clamped,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import pidc_pkg::*;

    pidc_cmd_t  cmd;
    pidc_stat_t stat;

    assign cfg_ready = 1'b1;

    pidc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pidc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_req_type (s_req_type),
        .s_setpoint (s_setpoint),
        .s_measured (s_measured),
        .cmd        (cmd),
        .stat       (stat),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_drive    (m_drive),
        .m_clamped  (m_clamped)
    );

endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID step block testbench
// Drives samples and register writes into the PID step block, predicts every
// drive/clamped result with a bit-exact fixed-point model, and compares the
// results in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import pidc_pkg::*;

    localparam logic signed [63:0] PI_W     = 64'sd205887;
    localparam logic signed [63:0] TWO_PI_W = 64'sd411775;
    localparam logic signed [63:0] ACC_HI   = 64'sd140737488355327;
    localparam logic signed [63:0] ACC_LO   = -64'sd140737488355328;
    localparam logic signed [63:0] W32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] W32_MIN  = -64'sd2147483648;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic signed [31:0] s_setpoint;
    logic signed [31:0] s_measured;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_drive;
    logic               m_clamped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
    } drive_res_t;

    drive_res_t  pending_drives[$];
    int          error_count;
    int          hold_cycles;
    bit          sink_stall_en;

    // gains and limits mirrored from the block
    logic signed [63:0] g_kp, g_ki, g_kd, g_kf, g_lim, g_dead, g_lo, g_hi;
    // controller state
    logic signed [63:0] acc, prev_meas, prev_tgt, prev_err, prev_drive;

    pid_controller_step u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [63:0] mag(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the controller by one sample and queue the expected result
    task automatic predict_drive(input logic angle, input logic signed [31:0] sp,
                                 input logic signed [31:0] ms);
        logic signed [63:0] tgt, meas, e, ae, ratio, p, iout, d, f, total, drv;
        drive_res_t r;
        tgt = sp;
        meas = ms;
        e = tgt - meas;
        ratio = 64'sd65536;
        if (angle) begin
            if (e > PI_W) e = e - TWO_PI_W;
            else if (e < -PI_W) e = e + TWO_PI_W;
        end
        e = clip(e, W32_MIN, W32_MAX);
        ae = mag(e);
        if (ae < g_dead) begin
            tgt = meas;
            e = 0;
            ae = 0;
        end else if (e > 0) begin
            e = e - g_dead;
            ae = mag(e);
        end else if (e < 0) begin
            e = e + g_dead;
            ae = mag(e);
        end
        if (g_lo != 0 || g_hi != 0) begin
            if (ae <= g_lo) begin
                ratio = 64'sd65536;
            end else if (ae >= g_hi) begin
                ratio = 0;
                acc = 0;
            end else if (g_hi - g_lo > 0) begin
                ratio = ((g_hi - ae) * 64'sd65536) / (g_hi - g_lo);
            end
        end
        p = floor_q16(g_kp * e);
        if ((g_lim != 0 && mag(prev_drive) >= g_lim) || (prev_err > 0 && e < 0)
                || (prev_err < 0 && e > 0))
            acc = 0;
        acc = clip(acc + floor_q16(g_ki * floor_q16(ratio * e)), ACC_LO, ACC_HI);
        iout = acc;
        d = clip(-floor_q16(g_kd * clip(meas - prev_meas, W32_MIN, W32_MAX)),
                 W32_MIN, W32_MAX);
        f = floor_q16(g_kf * clip(tgt - prev_tgt, W32_MIN, W32_MAX));
        total = p + iout + d + f;
        drv = total;
        if (g_lim != 0) drv = clip(drv, -g_lim, g_lim);
        drv = clip(drv, W32_MIN, W32_MAX);
        prev_meas = meas;
        prev_tgt = tgt;
        prev_drive = drv;
        prev_err = e;
        r.drive = drv[31:0];
        r.clamped = (drv != total);
        pending_drives.push_back(r);
    endtask

    // valid stays high after acceptance; a gap or idle drops it
    task automatic send_sample(input logic angle, input logic signed [31:0] sp,
                               input logic signed [31:0] ms);
        s_valid <= 1'b1;
        s_req_type <= angle;
        s_setpoint <= sp;
        s_measured <= ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_drive(angle, sp, ms);
    endtask

    task automatic send_gap();
        int n;
        n = rand_gap();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // wait for the block to drain, then let the slow divider path finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_KP:         g_kp = $signed(val);
            REG_KI_DT:      g_ki = {33'd0, val[30:0]};
            REG_KD_OVER_DT: g_kd = $signed(val);
            REG_KF:         g_kf = $signed(val);
            REG_OUT_LIMIT:  g_lim = {33'd0, val[30:0]};
            REG_DEAD_BAND:  g_dead = {33'd0, val[30:0]};
            REG_SLOW_LO:    g_lo = {33'd0, val[30:0]};
            default:        g_hi = {33'd0, val[30:0]};
        endcase
    endtask

    task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [31:0] kf,
                              input logic [31:0] lim, input logic [31:0] dead,
                              input logic [31:0] lo, input logic [31:0] hi);
        wait_idle();
        write_reg(REG_KP, kp);
        write_reg(REG_KI_DT, ki);
        write_reg(REG_KD_OVER_DT, kd);
        write_reg(REG_KF, kf);
        write_reg(REG_OUT_LIMIT, lim);
        write_reg(REG_DEAD_BAND, dead);
        write_reg(REG_SLOW_LO, lo);
        write_reg(REG_SLOW_HI, hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7FFFFFFF;
        if (r == 1) return 32'h80000000;
        if (r < 5) return $urandom();
        return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
    endfunction

    task automatic test_directed();
        load_gains(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_2000,
                   32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        send_sample(1'b0, 32'sh80000000, 32'sh7FFFFFFF);
        send_sample(1'b0, 32'sd0, 32'sd0);
        send_sample(1'b1, 32'sd300000, -32'sd300000);
        send_sample(1'b1, -32'sd300000, 32'sd300000);
        send_sample(1'b1, 32'sd205887, 32'sd0);
        send_sample(1'b1, 32'sd205888, 32'sd0);
        send_sample(1'b1, 32'sh7FFFFFFF, 32'sh80000000);
        send_sample(1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        // dead zone, slow band, output clamp
        load_gains(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                   32'h0008_0000, 32'h0000_1000, 32'h0001_0000, 32'h0004_0000);
        send_sample(1'b0, 32'sd100, 32'sd0);
        send_sample(1'b0, 32'sd4096, 32'sd0);
        send_sample(1'b0, 32'sd70000, 32'sd0);
        send_sample(1'b0, 32'sd150000, 32'sd0);
        send_sample(1'b0, 32'sd300000, 32'sd0);
        send_sample(1'b0, -32'sd150000, 32'sd0);
        send_sample(1'b0, 32'sh7FFFFFFF, 32'sd0);
        send_sample(1'b0, 32'sd150000, 32'sd1000);
        load_gains(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sample(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        send_sample(1'b0, 32'sh80000000, 32'sh7FFFFFFF);
        send_sample(1'b0, 32'sd5, 32'sd1);
    endtask

    task automatic test_random(input int n);
        int k;
        logic signed [31:0] sp, ms;
        for (k = 0; k < n; k++) begin
            if (k % 150 == 0) begin
                load_gains($urandom_range(0, 3) == 0 ? rand_word() :
                               $urandom_range(0, 262144),
                           $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 65536),
                           $urandom_range(0, 3) == 0 ? rand_word() :
                               $signed($urandom_range(0, 65536)) - 32'sd32768,
                           $urandom_range(0, 3) == 0 ? rand_word() :
                               $urandom_range(0, 65536),
                           $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(1, 4000000),
                           $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 20000),
                           $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 60000),
                           $urandom_range(0, 1) ? 32'd0 : $urandom_range(60000, 400000));
            end
            if ($urandom_range(0, 3) == 0) begin
                sp = rand_word();
                ms = rand_word();
            end else begin
                ms = $signed($urandom_range(0, 800000)) - 32'sd400000;
                sp = ms + $signed($urandom_range(0, 600000)) - 32'sd300000;
            end
            send_sample($urandom_range(0, 1), sp, ms);
            send_gap();
        end
    endtask

    task automatic test_backpressure();
        int k;
        hold_cycles = 300;
        for (k = 0; k < 30; k++)
            send_sample($urandom_range(0, 1), rand_word(), rand_word());
    endtask

    // sink: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (sink_stall_en) begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        drive_res_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected result drive=%0d clamped=%0b", $time,
                         m_drive, m_clamped);
                error_count++;
            end else begin
                exp_r = pending_drives.pop_front();
                if (m_drive !== exp_r.drive) begin
                    $display("%0t: drive mismatch expected %0d actual %0d", $time,
                             exp_r.drive, m_drive);
                    error_count++;
                end
                if (m_clamped !== exp_r.clamped) begin
                    $display("%0t: clamped mismatch expected %0b actual %0b", $time,
                             exp_r.clamped, m_clamped);
                    error_count++;
                end
            end
        end
    end

    initial begin
        error_count = 0;
        hold_cycles = 0;
        sink_stall_en = 1'b0;
        {g_kp, g_ki, g_kd, g_kf, g_lim, g_dead, g_lo, g_hi} = '0;
        {acc, prev_meas, prev_tgt, prev_err, prev_drive} = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_setpoint = '0;
        s_measured = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        sink_stall_en = 1'b1;
        test_random(1100);
        test_backpressure();
        wait_idle();
        if (error_count == 0 && pending_drives.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
